// ----- src/mrp_pkg.sv -----
// Package: shared types and codes for the min ratio path block
package mrp_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_PASS_INIT,
    ST_CLR,
    ST_EDGE_RD,
    ST_EDGE_WAIT,
    ST_FIND_A,
    ST_FIND_B,
    ST_UNION,
    ST_CHK_S,
    ST_CHK_T,
    ST_CMP_MUL,
    ST_CMP_DEC,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] REG_SOURCE_NODE = 2'd1;
  localparam logic [1:0] REG_TARGET_NODE = 2'd2;

  localparam int CfgDataBits = 10;
  localparam int NodeIdBits  = 9;
  localparam int OutBits     = 16;
  localparam int MaxNodes    = 512;
  localparam int WeightBits  = 16;

endpackage

// ----- src/mrp_if.sv -----
// Interfaces: valid/ready channels for edge words and result words
interface mrp_edge_if;
  logic       valid;
  logic       ready;
  logic [8:0] end_a;
  logic [8:0] end_b;
  logic [15:0] weight;
  logic       last_edge;
  modport source (output valid, end_a, end_b, weight, last_edge, input ready);
  modport sink (input valid, end_a, end_b, weight, last_edge, output ready);
endinterface

interface mrp_res_if;
  logic        valid;
  logic        ready;
  logic        reachable;
  logic [15:0] ratio_numerator;
  logic [15:0] ratio_denominator;
  modport source (output valid, reachable, ratio_numerator, ratio_denominator,
                  input ready);
  modport sink (input valid, reachable, ratio_numerator, ratio_denominator,
                output ready);
endinterface

// ----- src/mrp_ctrl.sv -----
// Controller: sequencer for sort, union-find passes, compare and reduction
module mrp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            trivial,
  input  logic            no_run,
  input  logic            sort_done_all,
  input  logic            sort_shift,
  input  logic            sort_at_bottom,
  input  logic            clr_done,
  input  logic            pass_end,
  input  logic            pass_all_done,
  input  logic            edge_ok,
  input  logic            walk_done,
  input  logic            roots_differ,
  input  logic            joined,
  input  logic            gcd_done,
  input  logic            div_done,
  input  logic            out_taken,
  output mrp_pkg::state_t state
);

  mrp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= mrp_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      mrp_pkg::ST_IDLE: begin
        if (start) begin
          if (trivial || no_run) state_next = mrp_pkg::ST_GCD;
          else state_next = mrp_pkg::ST_SORT_RD;
        end
      end
      mrp_pkg::ST_SORT_RD: begin
        if (sort_done_all) state_next = mrp_pkg::ST_PASS_INIT;
        else state_next = mrp_pkg::ST_SORT_KEY;
      end
      mrp_pkg::ST_SORT_KEY: state_next = mrp_pkg::ST_SORT_CMP;
      mrp_pkg::ST_SORT_CMP: begin
        if (sort_shift && !sort_at_bottom) state_next = mrp_pkg::ST_SORT_CMP;
        else state_next = mrp_pkg::ST_SORT_WR;
      end
      mrp_pkg::ST_SORT_WR: state_next = mrp_pkg::ST_SORT_RD;
      mrp_pkg::ST_PASS_INIT: begin
        if (pass_all_done) state_next = mrp_pkg::ST_GCD;
        else state_next = mrp_pkg::ST_CLR;
      end
      mrp_pkg::ST_CLR: if (clr_done) state_next = mrp_pkg::ST_EDGE_RD;
      mrp_pkg::ST_EDGE_RD: begin
        if (pass_end) state_next = mrp_pkg::ST_PASS_INIT;
        else state_next = mrp_pkg::ST_EDGE_WAIT;
      end
      mrp_pkg::ST_EDGE_WAIT: begin
        if (edge_ok) state_next = mrp_pkg::ST_FIND_A;
        else state_next = mrp_pkg::ST_CHK_S;
      end
      mrp_pkg::ST_FIND_A: if (walk_done) state_next = mrp_pkg::ST_FIND_B;
      mrp_pkg::ST_FIND_B: begin
        if (walk_done) begin
          if (roots_differ) state_next = mrp_pkg::ST_UNION;
          else state_next = mrp_pkg::ST_CHK_S;
        end
      end
      mrp_pkg::ST_UNION: state_next = mrp_pkg::ST_CHK_S;
      mrp_pkg::ST_CHK_S: if (walk_done) state_next = mrp_pkg::ST_CHK_T;
      mrp_pkg::ST_CHK_T: begin
        if (walk_done) begin
          if (joined) state_next = mrp_pkg::ST_CMP_MUL;
          else state_next = mrp_pkg::ST_EDGE_RD;
        end
      end
      mrp_pkg::ST_CMP_MUL: state_next = mrp_pkg::ST_CMP_DEC;
      mrp_pkg::ST_CMP_DEC: state_next = mrp_pkg::ST_PASS_INIT;
      mrp_pkg::ST_GCD: if (gcd_done) state_next = mrp_pkg::ST_DIV;
      mrp_pkg::ST_DIV: if (div_done) state_next = mrp_pkg::ST_OUT;
      mrp_pkg::ST_OUT: if (out_taken) state_next = mrp_pkg::ST_IDLE;
      default: state_next = mrp_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- src/mrp_datapath.sv -----
// Datapath: edge memory, parent memory, best ratio, gcd and divide units
module mrp_datapath #(
  parameter int MAX_EDGES   = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  mrp_pkg::state_t state,
  input  logic            in_fire,
  input  logic [8:0]      in_a,
  input  logic [8:0]      in_b,
  input  logic [15:0]     in_w,
  input  logic [9:0]      node_count,
  input  logic [8:0]      source_node,
  input  logic [8:0]      target_node,
  output logic            trivial,
  output logic            no_run,
  output logic            sort_done_all,
  output logic            sort_shift,
  output logic            sort_at_bottom,
  output logic            clr_done,
  output logic            pass_end,
  output logic            pass_all_done,
  output logic            edge_ok,
  output logic            walk_done,
  output logic            roots_differ,
  output logic            joined,
  output logic            gcd_done,
  output logic            div_done,
  output logic            res_reachable,
  output logic [15:0]     res_num,
  output logic [15:0]     res_den
);

  localparam int MAX_NODES = mrp_pkg::MaxNodes;
  localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CB = $clog2(MAX_EDGES + 1);
  localparam int LB = $clog2(MAX_NODES + 1);
  localparam int WB = mrp_pkg::WeightBits;
  localparam int EW = 2 * NB + WB;
  localparam logic [WB-1:0] WMAX = {WB{1'b1}};

  logic [EW-1:0] edge_mem [MAX_EDGES];
  logic [NB-1:0] par_mem [MAX_NODES];

  logic [CB-1:0] edge_count;
  logic [LB-1:0] lim;
  logic          src_ok, tgt_ok;
  logic [WB-1:0] w_in;

  assign w_in = WB'(in_w);
  assign lim = (LB'(node_count) > LB'(MAX_NODES)) ? LB'(MAX_NODES) : LB'(node_count);
  assign src_ok = LB'(source_node) < lim && 32'(source_node) < MAX_NODES;
  assign tgt_ok = LB'(target_node) < lim && 32'(target_node) < MAX_NODES;
  assign trivial = (source_node == target_node);
  assign no_run = !(src_ok && tgt_ok);

  // edge memory port
  logic [EB-1:0] ew_addr, er_addr;
  logic          ew_en;
  logic [EW-1:0] ew_data, er_data;

  always_ff @(posedge clk) begin
    if (ew_en) edge_mem[ew_addr] <= ew_data;
    er_data <= edge_mem[er_addr];
  end

  // parent memory port
  logic [NB-1:0] pw_addr, pr_addr, pr_data;
  logic          pw_en;
  logic [NB-1:0] pw_data;

  always_ff @(posedge clk) begin
    if (pw_en) par_mem[pw_addr] <= pw_data;
    pr_data <= par_mem[pr_addr];
  end

  // sort / pass registers
  logic [CB-1:0] si, sj, pi, pj;
  logic [EW-1:0] skey;
  logic [NB:0]   clr_k;
  logic [NB-1:0] walk_x, root_a, root_b, root_s;
  logic          walk_rd;
  logic [WB-1:0] cur_w, mn, mx;
  logic [NB-1:0] cur_b;
  logic [WB-1:0] best_low, best_high;
  logic          found_any;
  logic [2*WB-1:0] prod_l, prod_r;
  logic [WB-1:0] ga, gb, gd, dq, dr, dnum;
  logic [5:0]    dcnt;
  logic          div_phase;
  logic          second;
  logic [WB-1:0] qn;
  logic [WB:0]   dtrial;

  logic [WB-1:0] kw, sw;
  assign kw = skey[WB-1:0];
  assign sw = er_data[WB-1:0];
  assign dtrial = {dr, dnum[WB-1]};

  assign sort_done_all = (si >= edge_count);
  assign sort_at_bottom = (sj == CB'(1));
  assign sort_shift = (sw > kw);
  assign clr_done = (clr_k[NB-1:0] == NB'(lim - LB'(1))) || clr_k[NB];
  assign pass_end = (pj >= edge_count);
  assign pass_all_done = (pi >= edge_count);
  assign edge_ok = 32'(er_data[EW-1:EW-NB]) < 32'(lim) &&
                   32'(er_data[EW-NB-1:WB]) < 32'(lim);
  // walk finished when the read parent equals the node itself
  assign walk_done = walk_rd && (pr_data == walk_x);
  assign roots_differ = (root_a != pr_data);
  assign joined = (root_s == pr_data);
  assign gcd_done = div_phase && (gb == '0);
  assign div_done = second && dcnt == 6'(WB);

  always_comb begin
    ew_en = 1'b0;
    ew_addr = EB'(edge_count);
    ew_data = {in_a[NB-1:0], in_b[NB-1:0], w_in};
    er_addr = EB'(pj);
    pw_en = 1'b0;
    pw_addr = clr_k[NB-1:0];
    pw_data = clr_k[NB-1:0];
    pr_addr = walk_x;
    case (state)
      mrp_pkg::ST_IDLE: begin
        ew_en = in_fire && w_in != '0 && edge_count < CB'(MAX_EDGES);
      end
      mrp_pkg::ST_SORT_RD: er_addr = EB'(si);
      mrp_pkg::ST_SORT_KEY: er_addr = EB'(sj - CB'(1));
      mrp_pkg::ST_SORT_CMP: begin
        er_addr = EB'(sj - CB'(2));
        if (sort_shift) begin
          ew_en = 1'b1;
          ew_addr = EB'(sj);
          ew_data = er_data;
        end
      end
      mrp_pkg::ST_SORT_WR: begin
        ew_en = 1'b1;
        ew_addr = EB'(sj);
        ew_data = skey;
      end
      mrp_pkg::ST_CLR: pw_en = 1'b1;
      mrp_pkg::ST_FIND_A, mrp_pkg::ST_FIND_B, mrp_pkg::ST_CHK_S,
      mrp_pkg::ST_CHK_T: begin
        pr_addr = (walk_rd && pr_data != walk_x) ? pr_data : walk_x;
      end
      mrp_pkg::ST_UNION: begin
        pw_en = 1'b1;
        pw_addr = root_a;
        pw_data = root_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      found_any <= 1'b0;
      best_low <= WB'(1);
      best_high <= WMAX;
      walk_rd <= 1'b0;
      div_phase <= 1'b0;
      second <= 1'b0;
    end else begin
      case (state)
        mrp_pkg::ST_IDLE: begin
          if (ew_en) edge_count <= edge_count + CB'(1);
          si <= CB'(1);
          pi <= '0;
          found_any <= 1'b0;
          best_low <= WB'(1);
          best_high <= WMAX;
          div_phase <= 1'b0;
        end
        mrp_pkg::ST_SORT_RD: sj <= si;
        mrp_pkg::ST_SORT_KEY: skey <= er_data;
        mrp_pkg::ST_SORT_CMP: begin
          if (sort_shift) sj <= sj - CB'(1);
        end
        mrp_pkg::ST_SORT_WR: si <= si + CB'(1);
        mrp_pkg::ST_PASS_INIT: begin
          clr_k <= '0;
          pj <= pi;
          mn <= WMAX;
          mx <= '0;
        end
        mrp_pkg::ST_CLR: clr_k <= clr_k + (NB+1)'(1);
        mrp_pkg::ST_EDGE_RD: begin
          if (pass_end) pi <= pi + CB'(1);
          walk_rd <= 1'b0;
        end
        mrp_pkg::ST_EDGE_WAIT: begin
          cur_b <= er_data[EW-NB-1:WB];
          cur_w <= er_data[WB-1:0];
          walk_x <= edge_ok ? er_data[EW-1:EW-NB] : source_node[NB-1:0];
          walk_rd <= 1'b0;
          pj <= pj + CB'(1);
        end
        mrp_pkg::ST_FIND_A, mrp_pkg::ST_FIND_B, mrp_pkg::ST_CHK_S,
        mrp_pkg::ST_CHK_T: begin
          if (!walk_rd) walk_rd <= 1'b1;
          else if (pr_data != walk_x) walk_x <= pr_data;
          else begin
            walk_rd <= 1'b0;
            if (state == mrp_pkg::ST_FIND_A) begin
              root_a <= pr_data;
              walk_x <= cur_b;
            end else if (state == mrp_pkg::ST_FIND_B) begin
              root_b <= pr_data;
              walk_x <= source_node[NB-1:0];
            end else if (state == mrp_pkg::ST_CHK_S) begin
              root_s <= pr_data;
              walk_x <= target_node[NB-1:0];
            end else if (joined) begin
              pi <= pi + CB'(1);
            end
          end
        end
        mrp_pkg::ST_UNION: begin
          if (cur_w < mn) mn <= cur_w;
          if (cur_w > mx) mx <= cur_w;
          walk_x <= source_node[NB-1:0];
          walk_rd <= 1'b0;
        end
        mrp_pkg::ST_CMP_MUL: begin
          prod_l <= (2*WB)'(mx) * (2*WB)'(best_low);
          prod_r <= (2*WB)'(best_high) * (2*WB)'(mn);
        end
        mrp_pkg::ST_CMP_DEC: begin
          if (!found_any || prod_l < prod_r) begin
            best_low <= mn;
            best_high <= mx;
          end
          found_any <= 1'b1;
        end
        mrp_pkg::ST_GCD: begin
          if (!div_phase) begin
            div_phase <= 1'b1;
            ga <= found_any ? best_high : WB'(1);
            gb <= found_any ? best_low : '0;
          end else if (gb != '0) begin
            // subtractive gcd step
            if (ga >= gb) ga <= ga - gb;
            else begin
              ga <= gb;
              gb <= ga;
            end
          end else begin
            gd <= ga;
            dcnt <= '0;
            dr <= '0;
            dq <= '0;
            dnum <= best_high;
            second <= 1'b0;
          end
        end
        mrp_pkg::ST_DIV: begin
          // restoring division: best_high by gd, then best_low by gd
          if (dcnt != 6'(WB)) begin
            if (dtrial >= {1'b0, gd}) begin
              dr <= WB'(dtrial - {1'b0, gd});
              dq <= {dq[WB-2:0], 1'b1};
            end else begin
              dr <= dtrial[WB-1:0];
              dq <= {dq[WB-2:0], 1'b0};
            end
            dnum <= {dnum[WB-2:0], 1'b0};
            dcnt <= dcnt + 6'd1;
          end else if (!second) begin
            second <= 1'b1;
            qn <= dq;
            dcnt <= '0;
            dr <= '0;
            dnum <= best_low;
          end else begin
            res_reachable <= trivial || found_any;
            res_num <= trivial ? 16'd1 : (found_any ? 16'(qn) : 16'd0);
            res_den <= trivial ? 16'd1 : (found_any ? 16'(dq) : 16'd1);
          end
        end
        mrp_pkg::ST_OUT: edge_count <= '0;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/min_ratio_path_union_find.sv -----
// Top level: min max/min ratio path search over a loaded edge list
//  channel  dir  fields
//  edges    in   end_a end_b weight last_edge
//  result   out  reachable ratio_numerator ratio_denominator
//  cfg      in   cfg_we cfg_index cfg_data
// Edges load at one per cycle while the block is idle; a last_edge word starts the search.
// Search: insertion sort of the edges by weight, then up to E passes of
// clearing the parent memory and union-find walks on it.
// Reduction: subtractive gcd, then two serial restoring divides.
// Synchronous active-high reset; result waits in a register until taken.
module min_ratio_path_union_find #(
  parameter int MAX_EDGES   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  mrp_edge_if.sink    edges,
  mrp_res_if.source   result
);

  logic [9:0] node_count;
  logic [8:0] source_node, target_node;
  mrp_pkg::state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 10'd512;
      source_node <= 9'd0;
      target_node <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mrp_pkg::REG_NODE_COUNT:  node_count <= cfg_data;
        mrp_pkg::REG_SOURCE_NODE: source_node <= cfg_data[8:0];
        mrp_pkg::REG_TARGET_NODE: target_node <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic in_fire, start;
  assign edges.ready = (state == mrp_pkg::ST_IDLE);
  assign in_fire = edges.valid && edges.ready;
  assign start = in_fire && edges.last_edge;

  logic trivial, no_run, sort_done_all, sort_shift, sort_at_bottom, clr_done;
  logic pass_end, pass_all_done, edge_ok, walk_done, roots_differ, joined;
  logic gcd_done, div_done;

  mrp_ctrl u_ctrl (
    .clk, .rst, .start, .trivial, .no_run, .sort_done_all, .sort_shift,
    .sort_at_bottom, .clr_done, .pass_end, .pass_all_done, .edge_ok,
    .walk_done, .roots_differ, .joined, .gcd_done, .div_done,
    .out_taken(result.valid && result.ready), .state
  );

  mrp_datapath #(
    .MAX_EDGES(MAX_EDGES)
  ) u_dp (
    .clk, .rst, .state, .in_fire,
    .in_a(edges.end_a), .in_b(edges.end_b), .in_w(edges.weight),
    .node_count, .source_node, .target_node,
    .trivial, .no_run, .sort_done_all, .sort_shift, .sort_at_bottom,
    .clr_done, .pass_end, .pass_all_done, .edge_ok, .walk_done,
    .roots_differ, .joined, .gcd_done, .div_done,
    .res_reachable(result.reachable), .res_num(result.ratio_numerator),
    .res_den(result.ratio_denominator)
  );

  assign result.valid = (state == mrp_pkg::ST_OUT);

endmodule

// ----- src/mrp_checker.sv -----
// Checker: port-level properties of the min ratio path block
module mrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        reachable,
  input logic [15:0] num,
  input logic [15:0] den
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input open during result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(num) && $stable(den))
    else $error("result word changed while stalled");
  a_den_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> den != 16'd0) else $error("zero denominator");
  a_unreach: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reachable |-> num == 16'd0 && den == 16'd1)
    else $error("bad no-path word");
endmodule

bind min_ratio_path_union_find mrp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(edges.valid), .in_ready(edges.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .reachable(result.reachable), .num(result.ratio_numerator),
  .den(result.ratio_denominator)
);

// ----- tb/mrp_ratio_checker.sv -----
// Checker: predicts min ratio path results from observed edge words and compares
`timescale 1ns / 100ps
module mrp_ratio_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  mrp_edge_if         edges,
  mrp_res_if          result,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        reachable;
    logic [15:0] num;
    logic [15:0] den;
  } ratio_t;

  typedef struct {
    logic [8:0]  a;
    logic [8:0]  b;
    logic [15:0] w;
  } edge_t;

  edge_t       graph[$];
  ratio_t      ratio_q[$];
  logic [9:0]  n_nodes;
  logic [8:0]  src_node;
  logic [8:0]  dst_node;
  int unsigned uf_parent[512];

  function automatic int unsigned uf_root(int unsigned x);
    int unsigned r;
    int unsigned nx;
    r = x;
    while (uf_parent[r] != r) r = uf_parent[r];
    while (x != r) begin
      nx = uf_parent[x];
      uf_parent[x] = r;
      x = nx;
    end
    return r;
  endfunction

  function automatic ratio_t best_ratio();
    ratio_t      res;
    edge_t       sorted[$];
    edge_t       e;
    int unsigned lim;
    int unsigned mn;
    int unsigned mx;
    int unsigned lo;
    int unsigned hi;
    int unsigned x;
    int unsigned y;
    int unsigned t;
    int          j;
    bit          found;
    bit          joined;
    longint unsigned lhs;
    longint unsigned rhs;
    lim = (n_nodes < 512) ? n_nodes : 512;
    lo = 1;
    hi = 16'hffff;
    found = 0;
    res = '{reachable: 1'b0, num: 16'd0, den: 16'd1};
    if (src_node == dst_node) return '{reachable: 1'b1, num: 16'd1, den: 16'd1};
    if (src_node >= lim || dst_node >= lim) return res;
    sorted = {};
    foreach (graph[i]) begin
      e = graph[i];
      j = sorted.size();
      while (j > 0 && sorted[j - 1].w > e.w) j--;
      sorted.insert(j, e);
    end
    for (int i = 0; i < sorted.size(); i++) begin
      for (int k = 0; k < lim; k++) uf_parent[k] = k;
      mn = 16'hffff;
      mx = 0;
      joined = 0;
      for (int m = i; m < sorted.size(); m++) begin
        e = sorted[m];
        if (e.a < lim && e.b < lim) begin
          x = uf_root(e.a);
          y = uf_root(e.b);
          if (x != y) begin
            uf_parent[x] = y;
            if (e.w < mn) mn = e.w;
            if (e.w > mx) mx = e.w;
          end
        end
        if (uf_root(src_node) == uf_root(dst_node)) begin
          joined = 1;
          break;
        end
      end
      if (joined) begin
        lhs = longint'(mx) * lo;
        rhs = longint'(hi) * mn;
        if (!found || lhs < rhs) begin
          lo = mn;
          hi = mx;
        end
        found = 1;
      end
    end
    if (found && lo != 0) begin
      x = hi;
      y = lo;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      if (x == 0) x = 1;
      res.reachable = 1'b1;
      res.num = 16'(hi / x);
      res.den = 16'(lo / x);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    ratio_t want;
    if (rst) begin
      graph = {};
      ratio_q = {};
      n_nodes <= 10'd512;
      src_node <= 9'd0;
      dst_node <= 9'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mrp_pkg::REG_NODE_COUNT:  n_nodes <= cfg_data;
          mrp_pkg::REG_SOURCE_NODE: src_node <= cfg_data[8:0];
          mrp_pkg::REG_TARGET_NODE: dst_node <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (ratio_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = ratio_q.pop_front();
          if (result.reachable !== want.reachable)
            report_mismatch("reachable", result.reachable, want.reachable);
          if (result.ratio_numerator !== want.num)
            report_mismatch("numerator", result.ratio_numerator, want.num);
          if (result.ratio_denominator !== want.den)
            report_mismatch("denominator", result.ratio_denominator, want.den);
        end
      end
      if (edges.valid && edges.ready) begin
        if (edges.weight != 0 && graph.size() < 4096)
          graph.push_back('{a: edges.end_a, b: edges.end_b, w: edges.weight});
        if (edges.last_edge) begin
          ratio_q.push_back(best_ratio());
          graph = {};
        end
      end
    end
    pending = ratio_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end
endmodule

// ----- tb/min_ratio_path_union_find_test.sv -----
// Testbench top: drives edge graphs and config, runs checker, gives verdict
`timescale 1ns / 100ps
module min_ratio_path_union_find_test;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = mrp_pkg::REG_NODE_COUNT;
  logic [9:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         send_idle;
  int         recv_idle;
  int         n_words;
  int         n_graphs;
  longint     cycles;

  mrp_edge_if edges ();
  mrp_res_if  result ();

  min_ratio_path_union_find u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .edges(edges.sink), .result(result.source)
  );

  mrp_ratio_checker u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .edges(edges), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    edges.valid = 1'b0;
    edges.end_a = '0;
    edges.end_b = '0;
    edges.weight = '0;
    edges.last_edge = 1'b0;
    result.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd40_000_000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(input logic [8:0] a, input logic [8:0] b,
                           input logic [15:0] w, input logic last);
    while ($urandom_range(99) < send_idle) begin
      edges.valid <= 1'b0;
      @(posedge clk);
    end
    edges.valid <= 1'b1;
    edges.end_a <= a;
    edges.end_b <= b;
    edges.weight <= w;
    edges.last_edge <= last;
    @(posedge clk);
    while (!edges.ready) @(posedge clk);
    n_words++;
    if (last) n_graphs++;
  endtask

  task automatic wait_drained();
    edges.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_graph(input int n_edges, input int nodes);
    logic [8:0]  a;
    logic [8:0]  b;
    logic [15:0] w;
    int          hi;
    hi = (nodes > 1) ? nodes - 1 : 1;
    for (int i = 0; i < n_edges; i++) begin
      a = ($urandom_range(19) == 0) ? 9'($urandom) : 9'($urandom_range(hi));
      b = ($urandom_range(19) == 0) ? 9'($urandom) : 9'($urandom_range(hi));
      case ($urandom_range(5))
        0: w = 16'($urandom);
        1: w = 16'($urandom_range(65535, 60000));
        2: w = 16'($urandom_range(8, 1));
        default: w = 16'($urandom_range(200, 1));
      endcase
      if ($urandom_range(29) == 0) w = 16'd0;
      send_word(a, b, w, i == n_edges - 1);
    end
  endtask

  task automatic random_phase(input int s_idle, input int r_idle, input int n_items);
    int start;
    int sz;
    int nd;
    send_idle = s_idle;
    recv_idle = r_idle;
    start = n_words;
    while (n_words - start < n_items) begin
      wait_drained();
      nd = $urandom_range(8, 2);
      write_reg(mrp_pkg::REG_NODE_COUNT, 10'(nd));
      write_reg(mrp_pkg::REG_SOURCE_NODE, 10'($urandom_range(nd - 1)));
      write_reg(mrp_pkg::REG_TARGET_NODE, 10'($urandom_range(nd - 1)));
      sz = $urandom_range(12, 1);
      random_graph(sz, nd);
    end
  endtask

  initial begin
    cycles = 0;
    n_words = 0;
    n_graphs = 0;
    send_idle = 0;
    recv_idle = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: 512 nodes, 0 to 1
    send_word(9'd0, 9'd1, 16'hffff, 1'b0);
    send_word(9'd1, 9'd511, 16'd1, 1'b0);
    send_word(9'd0, 9'd511, 16'd0, 1'b1);
    send_word(9'd5, 9'd5, 16'd7, 1'b1);
    wait_drained();
    write_reg(mrp_pkg::REG_NODE_COUNT, 10'd1023);
    write_reg(mrp_pkg::REG_SOURCE_NODE, 10'd511);
    write_reg(mrp_pkg::REG_TARGET_NODE, 10'd0);
    send_word(9'd511, 9'd300, 16'd3, 1'b0);
    send_word(9'd300, 9'd0, 16'd6, 1'b0);
    send_word(9'd0, 9'd0, 16'd2, 1'b0);
    send_word(9'd511, 9'd0, 16'd12, 1'b1);
    wait_drained();
    write_reg(mrp_pkg::REG_NODE_COUNT, 10'd4);
    write_reg(mrp_pkg::REG_SOURCE_NODE, 10'd2);
    write_reg(mrp_pkg::REG_TARGET_NODE, 10'd2);
    send_word(9'd0, 9'd1, 16'd4, 1'b1);
    wait_drained();
    write_reg(mrp_pkg::REG_TARGET_NODE, 10'd3);
    send_word(9'd2, 9'd7, 16'd4, 1'b0);
    send_word(9'd7, 9'd3, 16'd4, 1'b0);
    send_word(9'd2, 9'd1, 16'd10, 1'b0);
    send_word(9'd1, 9'd3, 16'd15, 1'b0);
    send_word(9'd2, 9'd3, 16'd40, 1'b1);
    wait_drained();
    write_reg(mrp_pkg::REG_SOURCE_NODE, 10'd9);
    send_word(9'd2, 9'd3, 16'd1, 1'b1);
    wait_drained();
    write_reg(mrp_pkg::REG_NODE_COUNT, 10'd1);
    write_reg(mrp_pkg::REG_SOURCE_NODE, 10'd0);
    write_reg(mrp_pkg::REG_TARGET_NODE, 10'd0);
    send_word(9'd0, 9'd0, 16'd9, 1'b1);

    random_phase(33, 56, 300);
    random_phase(56, 33, 300);
    random_phase(0, 0, 300);
    wait_drained();

    $display("sent %0d edge words in %0d graphs, node counts 1 to 512", n_words, n_graphs);
    $display("covered unreachable, self, out of range and zero weight cases");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
